### rtl/rgbhsv_pkg.sv
package rgbhsv_pkg;

   // field widths
   localparam int unsigned CHAN_W = 8;
   localparam int unsigned HUE_W  = 15;
   localparam int unsigned SAT_W  = 13;

   // long division: partial remainder width and quotient bits per divide
   localparam int unsigned REM_W  = 23;
   localparam int unsigned QUO_W  = 15;

   // hue numerator width (sextant offset plus difference, below 6 * 255)
   localparam int unsigned NUM_W  = 11;

   // scale factors: 3840 units of hue per sextant, 4096 for full saturation
   localparam logic [12:0] HUE_SCALE = 13'd3840;
   localparam int unsigned SAT_SHIFT = 12;

   // sextant offsets in units of delta
   localparam logic [2:0] SEXT_GREEN = 3'd2;
   localparam logic [2:0] SEXT_BLUE  = 3'd4;
   localparam logic [2:0] SEXT_WRAP  = 3'd6;

   // word carried from cell to cell
   typedef struct packed {
      logic [REM_W-1:0]  hue_rem;
      logic [CHAN_W-1:0] hue_div;
      logic [QUO_W-1:0]  hue_quo;
      logic [REM_W-1:0]  sat_rem;
      logic [CHAN_W-1:0] sat_div;
      logic [QUO_W-1:0]  sat_quo;
      logic [CHAN_W-1:0] value;
      logic              grey;
      logic              black;
   } cell_word_type;

endpackage

### rtl/rgbhsv_pixel_if.sv
interface rgbhsv_pixel_if;
   logic                          valid;
   logic                          ready;
   logic [rgbhsv_pkg::CHAN_W-1:0] red;
   logic [rgbhsv_pkg::CHAN_W-1:0] green;
   logic [rgbhsv_pkg::CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/rgbhsv_hsv_if.sv
interface rgbhsv_hsv_if;
   logic                          valid;
   logic                          ready;
   logic [rgbhsv_pkg::HUE_W-1:0]  hue;
   logic [rgbhsv_pkg::SAT_W-1:0]  saturation;
   logic [rgbhsv_pkg::CHAN_W-1:0] value;

   modport source (output valid, output hue, output saturation, output value, input ready);
   modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

### rtl/rgbhsv_prep.sv
module rgbhsv_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] red,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] green,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] blue,
   output logic                          down_valid,
   input  logic                          down_ready,
   output rgbhsv_pkg::cell_word_type     down_word
);

   logic [rgbhsv_pkg::CHAN_W-1:0] max_val;
   logic [rgbhsv_pkg::CHAN_W-1:0] min_val;
   logic [rgbhsv_pkg::CHAN_W-1:0] delta;
   logic [rgbhsv_pkg::NUM_W-1:0]  delta_ext;
   logic [rgbhsv_pkg::NUM_W-1:0]  num;
   logic [rgbhsv_pkg::REM_W-1:0]  hue_dividend;
   logic                          valid_ff;
   logic                          valid_in;
   rgbhsv_pkg::cell_word_type     word_ff;
   rgbhsv_pkg::cell_word_type     word_in;
   logic                          load;

   // largest and smallest channel
   always_comb begin
      max_val = red;
      min_val = red;
      if (green > max_val) max_val = green;
      if (blue > max_val) max_val = blue;
      if (green < min_val) min_val = green;
      if (blue < min_val) min_val = blue;
   end

   assign delta     = max_val - min_val;
   assign delta_ext = rgbhsv_pkg::NUM_W'(delta);

   // sextant offset plus in-sextant difference, ties to red then green
   always_comb begin
      if (max_val == red) begin
         if (green >= blue) begin
            num = rgbhsv_pkg::NUM_W'(green - blue);
         end else begin
            num = rgbhsv_pkg::NUM_W'(rgbhsv_pkg::SEXT_WRAP) * delta_ext
                  - rgbhsv_pkg::NUM_W'(blue - green);
         end
      end else if (max_val == green) begin
         num = rgbhsv_pkg::NUM_W'(rgbhsv_pkg::SEXT_GREEN) * delta_ext
               + rgbhsv_pkg::NUM_W'(blue) - rgbhsv_pkg::NUM_W'(red);
      end else begin
         num = rgbhsv_pkg::NUM_W'(rgbhsv_pkg::SEXT_BLUE) * delta_ext
               + rgbhsv_pkg::NUM_W'(red) - rgbhsv_pkg::NUM_W'(green);
      end
   end

   assign hue_dividend = rgbhsv_pkg::REM_W'(num) * rgbhsv_pkg::REM_W'(rgbhsv_pkg::HUE_SCALE);

   // word for the first division cell
   always_comb begin
      word_in.hue_rem = hue_dividend;
      word_in.hue_div = delta;
      word_in.hue_quo = '0;
      word_in.sat_rem = rgbhsv_pkg::REM_W'(delta) << rgbhsv_pkg::SAT_SHIFT;
      word_in.sat_div = max_val;
      word_in.sat_quo = '0;
      word_in.value   = max_val;
      word_in.grey    = (delta == '0);
      word_in.black   = (max_val == '0);
   end

   // stage handshake
   assign up_ready = !valid_ff || down_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      valid_in = valid_ff;
      if (up_ready) valid_in = up_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_word  = word_ff;

endmodule

### rtl/rgbhsv_div_cell.sv
module rgbhsv_div_cell #(
   parameter int unsigned SHIFT = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  rgbhsv_pkg::cell_word_type up_word,
   output logic                      down_valid,
   input  logic                      down_ready,
   output rgbhsv_pkg::cell_word_type down_word
);

   logic [rgbhsv_pkg::REM_W-1:0] hue_trial;
   logic [rgbhsv_pkg::REM_W-1:0] sat_trial;
   logic                         valid_ff;
   logic                         valid_in;
   rgbhsv_pkg::cell_word_type    word_ff;
   rgbhsv_pkg::cell_word_type    word_in;
   logic                         load;

   // divisors lined up with this quotient bit
   assign hue_trial = rgbhsv_pkg::REM_W'(up_word.hue_div) << SHIFT;
   assign sat_trial = rgbhsv_pkg::REM_W'(up_word.sat_div) << SHIFT;

   // one restoring step per lane
   always_comb begin
      word_in = up_word;
      if (up_word.hue_rem >= hue_trial) begin
         word_in.hue_rem        = up_word.hue_rem - hue_trial;
         word_in.hue_quo[SHIFT] = 1'b1;
      end
      if (up_word.sat_rem >= sat_trial) begin
         word_in.sat_rem        = up_word.sat_rem - sat_trial;
         word_in.sat_quo[SHIFT] = 1'b1;
      end
   end

   // stage handshake
   assign up_ready = !valid_ff || down_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      valid_in = valid_ff;
      if (up_ready) valid_in = up_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_word  = word_ff;

endmodule

### rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter: takes one 8-bit RGB word per clock while rsp is ready, and
// returns one HSV word per word taken, in order. Hue is in 1/64 degree (0..23039,
// 0 for grey), saturation is scaled by 4096 (0..4096, 0 for black) and value is the
// largest channel; both divisions round down. A registered stage for max, min and
// the hue numerator feeds a row of 15 long-division cells, each settling one
// quotient bit of hue and of saturation. Throughput is one word per clock while rsp
// is ready; every stage holds its word while rsp is stalled and fills its bubbles.
module rgb_to_hsv_converter (
   input logic          clock,
   input logic          reset,
   rgbhsv_pixel_if.sink req,
   rgbhsv_hsv_if.source rsp
);

   localparam int unsigned CELLS = rgbhsv_pkg::QUO_W;

   logic                      chain_valid [CELLS+1];
   logic                      chain_ready [CELLS+1];
   rgbhsv_pkg::cell_word_type chain_word  [CELLS+1];

   // max, min and hue numerator
   rgbhsv_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req.valid),
      .up_ready   (req.ready),
      .red        (req.red),
      .green      (req.green),
      .blue       (req.blue),
      .down_valid (chain_valid[0]),
      .down_ready (chain_ready[0]),
      .down_word  (chain_word[0])
   );

   // division cells, most significant quotient bit first
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      rgbhsv_div_cell #(
         .SHIFT (CELLS - 1 - i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[i]),
         .up_ready   (chain_ready[i]),
         .up_word    (chain_word[i]),
         .down_valid (chain_valid[i+1]),
         .down_ready (chain_ready[i+1]),
         .down_word  (chain_word[i+1])
      );
   end

   // result word from the last cell
   assign chain_ready[CELLS] = rsp.ready;
   assign rsp.valid          = chain_valid[CELLS];
   assign rsp.hue            = chain_word[CELLS].grey ? '0
                               : rgbhsv_pkg::HUE_W'(chain_word[CELLS].hue_quo);
   assign rsp.saturation     = chain_word[CELLS].black ? '0
                               : rgbhsv_pkg::SAT_W'(chain_word[CELLS].sat_quo);
   assign rsp.value          = chain_word[CELLS].value;

endmodule

### tb/tb_rgb_to_hsv_converter.sv
module tb_rgb_to_hsv_converter;
   timeunit 1ns;
   timeprecision 1ps;

   // hue units per sextant and the saturation of a fully saturated colour
   localparam int unsigned HUE_PER_SEXTANT = 3840;
   localparam int unsigned SAT_FULL        = 4096;

   // quiet cycles at the end, ample for catching stray words once the pipeline is empty
   localparam int unsigned SETTLE_CYCLES  = 40;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned REPORT_LIMIT   = 10;

   typedef logic [rgbhsv_pkg::CHAN_W-1:0] channel_type;

   typedef struct packed {
      logic [rgbhsv_pkg::HUE_W-1:0]  hue;
      logic [rgbhsv_pkg::SAT_W-1:0]  saturation;
      logic [rgbhsv_pkg::CHAN_W-1:0] value;
   } hsv_word_type;

   logic clock;
   logic reset;

   rgbhsv_pixel_if pixel_bus ();
   rgbhsv_hsv_if   hsv_bus ();

   rgb_to_hsv_converter dut (
      .clock (clock),
      .reset (reset),
      .req   (pixel_bus),
      .rsp   (hsv_bus)
   );

   hsv_word_type hsv_expected[$];
   int unsigned  mismatch_count;
   int unsigned  burst_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hsv of one pixel: max channel, scaled spread, hue in 1/64 degree
   function automatic hsv_word_type hsv_of_pixel(input channel_type r, input channel_type g,
                                                 input channel_type b);
      int unsigned  rv, gv, bv, top, bottom, spread, numer;
      hsv_word_type w;
      rv = r;
      gv = g;
      bv = b;
      top = rv;
      if (gv > top) top = gv;
      if (bv > top) top = bv;
      bottom = rv;
      if (gv < bottom) bottom = gv;
      if (bv < bottom) bottom = bv;
      spread = top - bottom;
      w.value = rgbhsv_pkg::CHAN_W'(top);
      w.saturation = (top == 0) ? '0 : rgbhsv_pkg::SAT_W'((SAT_FULL * spread) / top);
      if (spread == 0) begin
         w.hue = '0;
      end else begin
         // red wins ties, then green; red sextant wraps below 360 degrees
         if (top == rv) begin
            if (gv >= bv) numer = gv - bv;
            else numer = int'(rgbhsv_pkg::SEXT_WRAP) * spread - (bv - gv);
         end else if (top == gv) begin
            numer = int'(rgbhsv_pkg::SEXT_GREEN) * spread + bv - rv;
         end else begin
            numer = int'(rgbhsv_pkg::SEXT_BLUE) * spread + rv - gv;
         end
         w.hue = rgbhsv_pkg::HUE_W'((HUE_PER_SEXTANT * numer) / spread);
      end
      return w;
   endfunction

   // send one pixel word, opening a new burst after a random gap when due
   task automatic send_pixel(input channel_type r, input channel_type g,
                             input channel_type b);
      int unsigned gap;
      bit          took;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            pixel_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 40);
      end
      pixel_bus.valid <= 1'b1;
      pixel_bus.red   <= r;
      pixel_bus.green <= g;
      pixel_bus.blue  <= b;
      do begin
         @(negedge clock);
         took = pixel_bus.ready;
         @(posedge clock);
      end while (!took);
      hsv_expected.push_back(hsv_of_pixel(r, g, b));
      burst_left--;
   endtask

   // black, greys, primaries, ties and the hue wrap
   task automatic test_directed_corners();
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd1,   8'd0);
      send_pixel(8'd255, 8'd254, 8'd255);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd0,   8'd1,   8'd1);
      send_pixel(8'd1,   8'd2,   8'd0);
      send_pixel(8'd0,   8'd170, 8'd85);
      send_pixel(8'd85,  8'd0,   8'd170);
      send_pixel(8'd100, 8'd37,  8'd200);
   endtask

   // random pixels: fully random, near grey, tied channels and edge values
   task automatic test_random_pixels(input int unsigned count);
      channel_type ch[3];
      channel_type base;
      int unsigned mode, k, a;
      repeat (count) begin
         mode = $urandom_range(0, 9);
         base = channel_type'($urandom_range(0, 255));
         for (k = 0; k < 3; k++) ch[k] = channel_type'($urandom_range(0, 255));
         if (mode >= 4 && mode <= 5) begin
            for (k = 0; k < 3; k++) begin
               a = base + $urandom_range(0, 4);
               ch[k] = (a > 2) ? channel_type'((a - 2 > 255) ? 255 : a - 2) : '0;
            end
         end else if (mode >= 6 && mode <= 7) begin
            k = $urandom_range(0, 2);
            ch[k] = ch[(k + 1) % 3];
         end else if (mode == 8) begin
            for (k = 0; k < 3; k++) begin
               case ($urandom_range(0, 3))
                  0: ch[k] = 8'd0;
                  1: ch[k] = 8'd1;
                  2: ch[k] = 8'd254;
                  default: ch[k] = 8'd255;
               endcase
            end
         end else if (mode == 9) begin
            ch[0] = base;
            ch[1] = base;
            ch[2] = base;
         end
         send_pixel(ch[0], ch[1], ch[2]);
      end
   endtask

   // sender holds off until every pending result has come back
   task automatic test_drain_hold_off();
      pixel_bus.valid <= 1'b0;
      while (hsv_expected.size() != 0) @(posedge clock);
      @(posedge clock);
      burst_left = 0;
      send_pixel(8'd12, 8'd200, 8'd99);
   endtask

   // receiver stall pattern: runs of always ready, coin toss, rare stall, rare ready
   initial begin : rsp_stall_pattern
      int unsigned stall_mode, run;
      hsv_bus.ready <= 1'b0;
      forever begin
         stall_mode = $urandom_range(0, 3);
         run = $urandom_range(20, 150);
         repeat (run) begin
            @(posedge clock);
            case (stall_mode)
               0: hsv_bus.ready <= 1'b1;
               1: hsv_bus.ready <= 1'($urandom_range(0, 1));
               2: hsv_bus.ready <= ($urandom_range(0, 7) != 0);
               default: hsv_bus.ready <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   // compare each returned word with the oldest prediction
   initial begin : hsv_checker
      hsv_word_type got, want;
      mismatch_count = 0;
      forever begin
         @(negedge clock);
         if (!reset && hsv_bus.valid === 1'b1 && hsv_bus.ready === 1'b1) begin
            got.hue        = hsv_bus.hue;
            got.saturation = hsv_bus.saturation;
            got.value      = hsv_bus.value;
            if (hsv_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected word: hue %0d sat %0d value %0d",
                           got.hue, got.saturation, got.value);
            end else begin
               want = hsv_expected.pop_front();
               if (got.hue !== want.hue || got.saturation !== want.saturation ||
                   got.value !== want.value) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("mismatch: expected hue %0d sat %0d value %0d, got %0d %0d %0d",
                              want.hue, want.saturation, want.value,
                              got.hue, got.saturation, got.value);
               end
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((pixel_bus.valid === 1'b1 && pixel_bus.ready === 1'b1) ||
             (hsv_bus.valid === 1'b1 && hsv_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // test sequence
   initial begin : test_sequence
      burst_left = 0;
      reset <= 1'b1;
      pixel_bus.valid <= 1'b0;
      pixel_bus.red   <= '0;
      pixel_bus.green <= '0;
      pixel_bus.blue  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_pixels(800);
      test_drain_hold_off();
      test_random_pixels(900);
      pixel_bus.valid <= 1'b0;

      // let the pipeline empty, then watch for stray words
      while (hsv_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && hsv_expected.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_pixel_if.sv
rtl/rgbhsv_hsv_if.sv
rtl/rgbhsv_prep.sv
rtl/rgbhsv_div_cell.sv
rtl/rgb_to_hsv_converter.sv
tb/tb_rgb_to_hsv_converter.sv
